@@ hw/rtl/lcd4w_pkg.sv @@
package lcd4w_pkg;

    // result targets
    localparam logic [1:0] TGT_DATA = 2'd0;
    localparam logic [1:0] TGT_DIR  = 2'd1;
    localparam logic [1:0] TGT_READ = 2'd2;

    // port bits and fixed values
    localparam logic [7:0] BIT_RS   = 8'h20;
    localparam logic [7:0] BIT_RD   = 8'h40;
    localparam logic [7:0] BIT_EN   = 8'h80;
    localparam logic [7:0] BIT_BUSY = 8'h08;
    localparam logic [7:0] DIR_POLL = 8'hf7;
    localparam logic [7:0] DIR_OUT  = 8'hff;
    localparam logic [7:0] MASK_HI  = 8'hf0;
    localparam logic [7:0] MASK_LO  = 8'h0f;

    // request codes
    localparam logic ACT_SEND = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // last step index of each sequence
    localparam logic [3:0] LAST_SEND        = 4'd3;
    localparam logic [3:0] LAST_POLL        = 4'd4;
    localparam logic [3:0] LAST_FINISH_ONE  = 4'd6;
    localparam logic [3:0] LAST_FINISH_BOTH = 4'd9;

    // sequence selected for an accepted transfer
    typedef enum logic [2:0] {
        PLAN_SEND   = 3'b001,
        PLAN_POLL   = 3'b010,
        PLAN_FINISH = 3'b100
    } plan_t;

    typedef struct packed {
        logic       action;
        logic [7:0] payload_byte;
        logic       is_data;
        logic       single_nibble;
        logic [7:0] port_read;
    } in_item_t;

    typedef struct packed {
        logic [1:0] target;
        logic [7:0] port_value;
        logic       last;
    } out_item_t;

endpackage

@@ hw/rtl/char_lcd_four_bit_writer_top.sv @@
// Character LCD writer, 4-bit bus on one 8-bit port.
// Input channel s_*: a send request (action 0) or the port value read back
// from the display (action 1), one transfer per item.
// Result channel m_*: port data writes, direction writes and read requests,
// with last high on the final result of each item. An item gives 0 to 10
// results: send 4, busy poll 5, finish 7 or 10, ignored items none.
// An accepted item is loaded into the sequence register; its results then
// pass through the result register to m_*, one per cycle unless stalled.
// Throughput: one result per cycle while m_ready does not stall, set by the
// single output register. The next item is accepted in the cycle that the
// last result of the current one is loaded, so items follow with no gap.
// Ignored items are accepted and leave s_ready high for the next item.
// Reset (aresetn low, synchronous) drops any pending sequence and result and
// returns the block to idle with no read request outstanding.
// A stall on m_ready holds the result register; the sequence waits, and
// s_ready stays low until its last result is loaded into that register.
module char_lcd_four_bit_writer_top
    import lcd4w_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // protocol state
    logic       waiting_busy_reg, waiting_busy_next;
    logic [7:0] held_byte_reg;
    logic       held_is_data_reg;
    logic       held_single_reg;

    // sequence register
    logic       plan_valid_reg, plan_valid_next;
    plan_t      plan_kind_reg, plan_kind_next;
    logic [3:0] plan_last_reg, plan_last_next;
    logic [3:0] step_reg, step_next;
    logic [7:0] hi_nib_reg, hi_nib_next;
    logic [7:0] lo_nib_reg, lo_nib_next;

    // result register
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;

    logic       s_accept;
    logic       step_go;
    logic       step_done;
    logic       new_plan;
    logic [7:0] rs_bit;
    out_item_t  step_item;

    assign step_go   = plan_valid_reg && (!m_valid_reg || m_ready);
    assign step_done = step_go && (step_reg == plan_last_reg);
    assign s_ready   = !plan_valid_reg || step_done;
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // decide the sequence for an accepted transfer
    always_comb begin
        waiting_busy_next = waiting_busy_reg;
        new_plan          = 1'b0;
        plan_kind_next    = plan_kind_reg;
        plan_last_next    = plan_last_reg;
        hi_nib_next       = hi_nib_reg;
        lo_nib_next       = lo_nib_reg;
        rs_bit            = held_is_data_reg ? BIT_RS : 8'h00;
        if (s_accept) begin
            if (s_data.action == ACT_SEND) begin
                if (!waiting_busy_reg) begin
                    waiting_busy_next = 1'b1;
                    new_plan          = 1'b1;
                    plan_kind_next    = PLAN_SEND;
                    plan_last_next    = LAST_SEND;
                end
            end else begin
                if (waiting_busy_reg) begin
                    new_plan = 1'b1;
                    if ((s_data.port_read & BIT_BUSY) != 8'h00) begin
                        plan_kind_next = PLAN_POLL;
                        plan_last_next = LAST_POLL;
                    end else begin
                        waiting_busy_next = 1'b0;
                        plan_kind_next    = PLAN_FINISH;
                        plan_last_next    = held_single_reg ? LAST_FINISH_ONE
                                                            : LAST_FINISH_BOTH;
                        hi_nib_next = ((held_byte_reg & MASK_HI) >> 4) | rs_bit;
                        lo_nib_next = (held_byte_reg & MASK_LO) | rs_bit;
                    end
                end
            end
        end
    end

    // sequence progress
    always_comb begin
        plan_valid_next = plan_valid_reg;
        step_next       = step_reg;
        if (step_go) begin
            step_next = step_reg + 4'd1;
        end
        if (step_done) begin
            plan_valid_next = 1'b0;
        end
        if (new_plan) begin
            plan_valid_next = 1'b1;
            step_next       = 4'd0;
        end
    end

    // result of the current step
    always_comb begin
        step_item.target     = TGT_DATA;
        step_item.port_value = 8'h00;
        step_item.last       = (step_reg == plan_last_reg);
        case (plan_kind_reg)
            PLAN_SEND: begin
                case (step_reg)
                    4'd0: begin
                        step_item.target     = TGT_DIR;
                        step_item.port_value = DIR_POLL;
                    end
                    4'd1: step_item.port_value = BIT_RD;
                    4'd2: step_item.port_value = BIT_RD | BIT_EN;
                    default: step_item.target = TGT_READ;
                endcase
            end
            PLAN_POLL: begin
                case (step_reg)
                    4'd0, 4'd2: step_item.port_value = BIT_RD;
                    4'd1, 4'd3: step_item.port_value = BIT_RD | BIT_EN;
                    default: step_item.target = TGT_READ;
                endcase
            end
            PLAN_FINISH: begin
                case (step_reg)
                    4'd0, 4'd2: step_item.port_value = BIT_RD;
                    4'd1: step_item.port_value = BIT_RD | BIT_EN;
                    4'd3: begin
                        step_item.target     = TGT_DIR;
                        step_item.port_value = DIR_OUT;
                    end
                    4'd4, 4'd6: step_item.port_value = hi_nib_reg;
                    4'd5: step_item.port_value = hi_nib_reg | BIT_EN;
                    4'd8: step_item.port_value = lo_nib_reg | BIT_EN;
                    default: step_item.port_value = lo_nib_reg;
                endcase
            end
            default: step_item.target = TGT_DATA;
        endcase
    end

    // result register loading
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (step_go) begin
            m_valid_next = 1'b1;
            m_data_next  = step_item;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waiting_busy_reg <= 1'b0;
            plan_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            waiting_busy_reg <= waiting_busy_next;
            plan_valid_reg   <= plan_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        plan_kind_reg <= plan_kind_next;
        plan_last_reg <= plan_last_next;
        step_reg      <= step_next;
        hi_nib_reg    <= hi_nib_next;
        lo_nib_reg    <= lo_nib_next;
        m_data_reg    <= m_data_next;
        if (s_accept && (s_data.action == ACT_SEND) && !waiting_busy_reg) begin
            held_byte_reg    <= s_data.payload_byte;
            held_is_data_reg <= s_data.is_data;
            held_single_reg  <= s_data.single_nibble;
        end
    end

endmodule

@@ tb/char_lcd_four_bit_writer_top_tb.sv @@
module char_lcd_four_bit_writer_top_tb;
    import lcd4w_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    char_lcd_four_bit_writer_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // shadow of the writer state
    logic       poll_open;
    logic [7:0] pend_byte;
    logic       pend_rs;
    logic       pend_single;

    // port accesses still owed by the block, oldest first
    out_item_t port_access_q [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int errors;
    int items_sent;
    int items_ignored;
    int accesses_seen;
    int typed_ix;

    // directed rows; n_typed < 0 means the accesses come from the predictor
    typedef struct {
        in_item_t item;
        int       n_typed;
    } dir_row_t;

    localparam int N_DIR   = 21;
    localparam int N_TYPED = 24;

    dir_row_t dir_rows [N_DIR] = '{
        // stray port value straight after reset
        '{'{ACT_READ, 8'h00, 1'b0, 1'b0, 8'h00}, 0},
        '{'{ACT_SEND, 8'h00, 1'b0, 1'b0, 8'hff}, 4},
        // send while a read request is outstanding
        '{'{ACT_SEND, 8'hff, 1'b1, 1'b1, 8'h00}, 0},
        '{'{ACT_READ, 8'h00, 1'b0, 1'b0, 8'h08}, 5},
        '{'{ACT_READ, 8'hff, 1'b1, 1'b1, 8'hff}, 5},
        // busy clear, command 0x00 in two nibbles
        '{'{ACT_READ, 8'hff, 1'b1, 1'b1, 8'hf7}, 10},
        '{'{ACT_READ, 8'h00, 1'b0, 1'b0, 8'hff}, 0},
        '{'{ACT_SEND, 8'hff, 1'b1, 1'b0, 8'h00}, -1},
        '{'{ACT_READ, 8'h00, 1'b0, 1'b0, 8'h00}, -1},
        '{'{ACT_SEND, 8'h30, 1'b0, 1'b1, 8'h5a}, -1},
        '{'{ACT_READ, 8'h30, 1'b1, 1'b0, 8'h08}, -1},
        '{'{ACT_READ, 8'h30, 1'b0, 1'b1, 8'h07}, -1},
        '{'{ACT_SEND, 8'ha5, 1'b1, 1'b1, 8'h00}, -1},
        '{'{ACT_READ, 8'h00, 1'b0, 1'b0, 8'h00}, -1},
        '{'{ACT_SEND, 8'h5a, 1'b0, 1'b0, 8'h08}, -1},
        '{'{ACT_READ, 8'h5a, 1'b1, 1'b1, 8'hf7}, -1},
        '{'{ACT_SEND, 8'h0f, 1'b1, 1'b0, 8'hf0}, -1},
        '{'{ACT_SEND, 8'hf0, 1'b0, 1'b1, 8'h0f}, -1},
        '{'{ACT_READ, 8'h0f, 1'b1, 1'b0, 8'h88}, -1},
        '{'{ACT_READ, 8'hf0, 1'b0, 1'b1, 8'h77}, -1},
        '{'{ACT_READ, 8'h00, 1'b0, 1'b0, 8'h08}, -1}
    };

    // accesses of the typed rows, in row order
    out_item_t typed_acc [N_TYPED] = '{
        '{TGT_DIR,  DIR_POLL,      1'b0},
        '{TGT_DATA, BIT_RD,        1'b0},
        '{TGT_DATA, BIT_RD|BIT_EN, 1'b0},
        '{TGT_READ, 8'h00,         1'b1},
        '{TGT_DATA, BIT_RD,        1'b0},
        '{TGT_DATA, BIT_RD|BIT_EN, 1'b0},
        '{TGT_DATA, BIT_RD,        1'b0},
        '{TGT_DATA, BIT_RD|BIT_EN, 1'b0},
        '{TGT_READ, 8'h00,         1'b1},
        '{TGT_DATA, BIT_RD,        1'b0},
        '{TGT_DATA, BIT_RD|BIT_EN, 1'b0},
        '{TGT_DATA, BIT_RD,        1'b0},
        '{TGT_DATA, BIT_RD|BIT_EN, 1'b0},
        '{TGT_READ, 8'h00,         1'b1},
        '{TGT_DATA, BIT_RD,        1'b0},
        '{TGT_DATA, BIT_RD|BIT_EN, 1'b0},
        '{TGT_DATA, BIT_RD,        1'b0},
        '{TGT_DIR,  DIR_OUT,       1'b0},
        '{TGT_DATA, 8'h00,         1'b0},
        '{TGT_DATA, BIT_EN,        1'b0},
        '{TGT_DATA, 8'h00,         1'b0},
        '{TGT_DATA, 8'h00,         1'b0},
        '{TGT_DATA, BIT_EN,        1'b0},
        '{TGT_DATA, 8'h00,         1'b1}
    };

    function automatic out_item_t port_op(input logic [1:0] tgt, input logic [7:0] val);
        out_item_t op;
        op.target     = tgt;
        op.port_value = val;
        op.last       = 1'b0;
        return op;
    endfunction

    // port accesses caused by one item, updating the shadow state
    function automatic int lcd_predict(input in_item_t it, output out_item_t seq [10]);
        int         n;
        logic [7:0] rs;
        logic [7:0] nib;
        n = 0;
        if (it.action == ACT_SEND) begin
            if (poll_open) begin
                return 0;
            end
            pend_byte   = it.payload_byte;
            pend_rs     = it.is_data;
            pend_single = it.single_nibble;
            seq[0] = port_op(TGT_DIR, DIR_POLL);
            seq[1] = port_op(TGT_DATA, BIT_RD);
            seq[2] = port_op(TGT_DATA, BIT_RD | BIT_EN);
            seq[3] = port_op(TGT_READ, 8'h00);
            n = 4;
            poll_open = 1'b1;
        end else begin
            if (!poll_open) begin
                return 0;
            end
            seq[0] = port_op(TGT_DATA, BIT_RD);
            seq[1] = port_op(TGT_DATA, BIT_RD | BIT_EN);
            if ((it.port_read & BIT_BUSY) != 8'h00) begin
                // display still busy: poll again
                seq[2] = port_op(TGT_DATA, BIT_RD);
                seq[3] = port_op(TGT_DATA, BIT_RD | BIT_EN);
                seq[4] = port_op(TGT_READ, 8'h00);
                n = 5;
            end else begin
                rs = pend_rs ? BIT_RS : 8'h00;
                seq[2] = port_op(TGT_DATA, BIT_RD);
                seq[3] = port_op(TGT_DIR, DIR_OUT);
                n = 4;
                for (int k = 0; k < (pend_single ? 1 : 2); k++) begin
                    nib = (k == 0) ? ((pend_byte & MASK_HI) >> 4) | rs
                                   : (pend_byte & MASK_LO) | rs;
                    seq[n]     = port_op(TGT_DATA, nib);
                    seq[n + 1] = port_op(TGT_DATA, nib | BIT_EN);
                    seq[n + 2] = port_op(TGT_DATA, nib);
                    n += 3;
                end
                poll_open = 1'b0;
            end
        end
        seq[n - 1].last = 1'b1;
        return n;
    endfunction

    // present one item, holding it until the transfer
    task automatic offer(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // queue what the item owes, then send it
    task automatic run_item(input in_item_t it, input int n_typed);
        out_item_t seq [10];
        int        n;
        n = lcd_predict(it, seq);
        if (n == 0) begin
            items_ignored++;
        end
        if (n_typed < 0) begin
            for (int i = 0; i < n; i++) port_access_q.push_back(seq[i]);
        end else begin
            for (int i = 0; i < n_typed; i++) begin
                port_access_q.push_back(typed_acc[typed_ix]);
                typed_ix++;
            end
        end
        offer(it);
        items_sent++;
    endtask

    // mostly well-formed send/poll sequences, with stray items mixed in
    task automatic random_phase(input int n_items, input int idle_pct, input int stall_pct,
                                input int hold);
        in_item_t it;
        int       counted;
        logic     busy;
        counted        = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_cycles    = hold;
        while (counted < n_items) begin
            it.payload_byte  = 8'($urandom);
            it.is_data       = 1'($urandom_range(1));
            it.single_nibble = 1'($urandom_range(1));
            it.port_read     = 8'($urandom);
            if (!poll_open) begin
                it.action = ($urandom_range(99) < 88) ? ACT_SEND : ACT_READ;
            end else begin
                it.action = ($urandom_range(99) < 10) ? ACT_SEND : ACT_READ;
                busy = ($urandom_range(99) < 35);
                it.port_read = busy ? (it.port_read | BIT_BUSY) : (it.port_read & ~BIT_BUSY);
            end
            counted++;
            run_item(it, -1);
        end
    endtask

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stalls, or a long hold-off when asked
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each result transfer with the oldest owed access
    always @(posedge aclk) begin : access_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            accesses_seen++;
            if (port_access_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected access target=%0d value=%02h last=%0b",
                         $time, m_data.target, m_data.port_value, m_data.last);
            end else begin
                want = port_access_q.pop_front();
                if (m_data.target !== want.target) begin
                    errors++;
                    $display("%0t: target expected %0d got %0d",
                             $time, want.target, m_data.target);
                end
                if (m_data.port_value !== want.port_value) begin
                    errors++;
                    $display("%0t: port_value expected %02h got %02h",
                             $time, want.port_value, m_data.port_value);
                end
                if (m_data.last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %0b got %0b",
                             $time, want.last, m_data.last);
                end
            end
        end
    end

    // overall time limit
    initial begin
        #2000000;
        $display("char_lcd_four_bit_writer_top test failed");
        $finish;
    end

    // stimulus
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        errors         = 0;
        items_sent     = 0;
        items_ignored  = 0;
        accesses_seen  = 0;
        typed_ix       = 0;
        poll_open      = 1'b0;
        pend_byte      = 8'h00;
        pend_rs        = 1'b0;
        pend_single    = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table, no idling
        foreach (dir_rows[r]) begin
            run_item(dir_rows[r].item, dir_rows[r].n_typed);
        end

        // random phases; the first holds off the result side for a long stretch
        random_phase(37, 0, 0, 80);
        random_phase(37, 73, 0, 0);
        random_phase(37, 0, 73, 0);
        random_phase(37, 10, 10, 0);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (port_access_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("ran %0d items (%0d ignored strays) giving %0d port accesses,",
                 items_sent, items_ignored, accesses_seen);
        $display("across idle, sender-gap, receiver-stall and mixed phases plus a long hold-off");
        if (errors == 0) begin
            $display("char_lcd_four_bit_writer_top test passed");
        end else begin
            $display("char_lcd_four_bit_writer_top test failed");
        end
        $finish;
    end

endmodule
